@@ rtl/rc5_pkg.sv @@
// Shared types, codes and the sequencer control store for the RC5-32 block decrypter.
package rc5_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned ROUND_CNT_W = 5;
	localparam int unsigned KEY_IDX_W = 6;
	localparam logic [ROUND_CNT_W-1:0] ROUND_RESET = 5'd12;
	localparam logic [4:0] ROT_MASK = 5'h1f;

	localparam logic OP_KEY_WRITE = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	localparam int unsigned PC_W = 2;
	localparam logic [PC_W-1:0] PC_IDLE = 2'd0;
	localparam logic [PC_W-1:0] PC_ROUND = 2'd1;
	localparam logic [PC_W-1:0] PC_FINAL = 2'd2;

	typedef struct packed {
		logic operation;
		logic [KEY_IDX_W-1:0] key_index;
		logic [WORD_W-1:0] key_word;
		logic [WORD_W-1:0] cipher_a;
		logic [WORD_W-1:0] cipher_b;
	} in_word_t;

	typedef struct packed {
		logic [WORD_W-1:0] plain_a;
		logic [WORD_W-1:0] plain_b;
	} out_word_t;

	typedef enum logic [1:0] {
		BR_NONE = 2'd0,
		BR_START = 2'd1,
		BR_CNT = 2'd2
	} branch_t;

	typedef struct packed {
		logic take_in;
		logic wait_out;
		logic do_round;
		logic do_final;
		logic cnt_dec;
		branch_t br;
		logic [PC_W-1:0] next_pc;
		logic [PC_W-1:0] jump_pc;
	} uword_t;

	typedef struct packed {
		logic load;
		logic round;
		logic fin;
	} dp_ctl_t;

	// control store: idle waits for a word, round loops on the counter,
	// final subtracts S[1]/S[0] and can take the next word in the same cycle
	function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
		uword_t uw;
		uw = '{take_in: 1'b0, wait_out: 1'b0, do_round: 1'b0, do_final: 1'b0,
			cnt_dec: 1'b0, br: BR_NONE, next_pc: PC_IDLE, jump_pc: PC_IDLE};
		case (pc)
			PC_IDLE: begin
				uw.take_in = 1'b1;
				uw.br = BR_START;
				uw.next_pc = PC_IDLE;
				uw.jump_pc = PC_ROUND;
			end
			PC_ROUND: begin
				uw.do_round = 1'b1;
				uw.cnt_dec = 1'b1;
				uw.br = BR_CNT;
				uw.next_pc = PC_ROUND;
				uw.jump_pc = PC_FINAL;
			end
			PC_FINAL: begin
				uw.take_in = 1'b1;
				uw.wait_out = 1'b1;
				uw.do_final = 1'b1;
				uw.br = BR_START;
				uw.next_pc = PC_IDLE;
				uw.jump_pc = PC_ROUND;
			end
			default: begin
				uw.next_pc = PC_IDLE;
			end
		endcase
		return uw;
	endfunction

endpackage

@@ rtl/rc5_key_mem.sv @@
// Expanded key table: one write port, two registered read ports (S[2i+1] and S[2i]).
module rc5_key_mem #(
	parameter int unsigned MAX_ROUNDS = 16
) (
	input  logic clk,
	input  logic wr_en,
	input  logic [rc5_pkg::KEY_IDX_W-1:0] wr_index,
	input  logic [rc5_pkg::WORD_W-1:0] wr_data,
	input  logic [$clog2(MAX_ROUNDS+1)-1:0] rd_round,
	output logic [rc5_pkg::WORD_W-1:0] rd_hi,
	output logic [rc5_pkg::WORD_W-1:0] rd_lo
);

	localparam int unsigned KeyDepth = 2 * MAX_ROUNDS + 2;
	localparam int unsigned AddrW = $clog2(KeyDepth);

	logic [rc5_pkg::WORD_W-1:0] mem_q [KeyDepth];
	logic [AddrW-1:0] wr_addr;
	logic [AddrW-1:0] rd_addr_hi;
	logic [AddrW-1:0] rd_addr_lo;
	logic wr_in_range;

	assign wr_in_range = 32'(wr_index) < KeyDepth;
	assign wr_addr = AddrW'(wr_index);
	assign rd_addr_hi = AddrW'({rd_round, 1'b1});
	assign rd_addr_lo = AddrW'({rd_round, 1'b0});

	always_ff @(posedge clk) begin
		if (wr_en && wr_in_range) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_hi <= mem_q[rd_addr_hi];
		rd_lo <= mem_q[rd_addr_lo];
	end

endmodule

@@ rtl/rc5_seq.sv @@
// Microcoded sequencer: program counter, control store lookup, round counter, input handshake.
module rc5_seq #(
	parameter int unsigned MAX_ROUNDS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic operation,
	input  logic [rc5_pkg::ROUND_CNT_W-1:0] round_count,
	input  logic out_free,
	output logic in_stall,
	output logic key_wr,
	output logic [$clog2(MAX_ROUNDS+1)-1:0] rd_round,
	output rc5_pkg::dp_ctl_t ctl
);

	localparam int unsigned CntW = $clog2(MAX_ROUNDS + 1);

	logic [rc5_pkg::PC_W-1:0] pc_q;
	logic [rc5_pkg::PC_W-1:0] pc_d;
	logic [CntW-1:0] cnt_q;
	logic [CntW-1:0] cnt_d;
	logic [CntW-1:0] rounds_sat;
	rc5_pkg::uword_t uw;
	logic go;
	logic in_acc;
	logic dec_acc;

	assign uw = rc5_pkg::ucode_rom(pc_q);
	assign go = !uw.wait_out || out_free;
	assign in_stall = !(uw.take_in && go);
	assign in_acc = in_valid && !in_stall;
	assign dec_acc = in_acc && (operation == rc5_pkg::OP_DECRYPT);
	assign key_wr = in_acc && (operation == rc5_pkg::OP_KEY_WRITE);

	always_comb begin
		if (32'(round_count) > MAX_ROUNDS) begin
			rounds_sat = CntW'(MAX_ROUNDS);
		end else begin
			rounds_sat = CntW'(round_count);
		end
	end

	always_comb begin
		if (dec_acc) begin
			cnt_d = rounds_sat;
		end else if (uw.cnt_dec) begin
			cnt_d = cnt_q - CntW'(1);
		end else begin
			cnt_d = cnt_q;
		end
	end

	// prefetch keys for the round the counter will hold next; zero fetches S[1], S[0]
	assign rd_round = cnt_d;

	always_comb begin
		pc_d = uw.next_pc;
		if (!go) begin
			pc_d = pc_q;
		end else begin
			case (uw.br)
				rc5_pkg::BR_START: begin
					if (dec_acc) begin
						pc_d = (rounds_sat == '0) ? rc5_pkg::PC_FINAL : uw.jump_pc;
					end
				end
				rc5_pkg::BR_CNT: begin
					if (cnt_q == CntW'(1)) begin
						pc_d = uw.jump_pc;
					end
				end
				default: begin
					pc_d = uw.next_pc;
				end
			endcase
		end
	end

	assign ctl.load = dec_acc;
	assign ctl.round = uw.do_round;
	assign ctl.fin = uw.do_final && go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= rc5_pkg::PC_IDLE;
			cnt_q <= '0;
		end else begin
			pc_q <= pc_d;
			cnt_q <= cnt_d;
		end
	end

	a_round_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == rc5_pkg::PC_ROUND) |-> (cnt_q != '0))
		else $error("round step with exhausted counter");

	a_final_cnt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == rc5_pkg::PC_FINAL) |-> (cnt_q == '0))
		else $error("final step before all rounds done");

	a_start_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(dec_acc && (rounds_sat != '0)) |=> (pc_q == rc5_pkg::PC_ROUND && cnt_q != '0))
		else $error("block start did not enter rounds");

endmodule

@@ rtl/rc5_dp.sv @@
// Datapath: A/B working registers, one full decryption round per cycle, final subtract, output register.
module rc5_dp (
	input  logic clk,
	input  logic arst_n,
	input  rc5_pkg::dp_ctl_t ctl,
	input  logic [rc5_pkg::WORD_W-1:0] cipher_a,
	input  logic [rc5_pkg::WORD_W-1:0] cipher_b,
	input  logic [rc5_pkg::WORD_W-1:0] key_hi,
	input  logic [rc5_pkg::WORD_W-1:0] key_lo,
	input  logic out_stall,
	output logic out_valid,
	output rc5_pkg::out_word_t out_word,
	output logic out_free
);

	logic [rc5_pkg::WORD_W-1:0] a_q;
	logic [rc5_pkg::WORD_W-1:0] b_q;
	logic [rc5_pkg::WORD_W-1:0] b_rnd;
	logic [rc5_pkg::WORD_W-1:0] a_rnd;
	logic out_valid_q;
	rc5_pkg::out_word_t out_q;

	function automatic logic [rc5_pkg::WORD_W-1:0] rotr(
		input logic [rc5_pkg::WORD_W-1:0] x,
		input logic [rc5_pkg::WORD_W-1:0] amt
	);
		logic [2*rc5_pkg::WORD_W-1:0] dbl;
		dbl = {x, x} >> (amt[4:0] & rc5_pkg::ROT_MASK);
		return dbl[rc5_pkg::WORD_W-1:0];
	endfunction

	assign b_rnd = rotr(b_q - key_hi, a_q) ^ a_q;
	assign a_rnd = rotr(a_q - key_lo, b_rnd) ^ b_rnd;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= cipher_a;
			b_q <= cipher_b;
		end else if (ctl.round) begin
			a_q <= a_rnd;
			b_q <= b_rnd;
		end
		if (ctl.fin) begin
			out_q.plain_a <= a_q - key_lo;
			out_q.plain_b <= b_q - key_hi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word = out_q;

	a_final_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fin |-> (!out_valid_q || !out_stall))
		else $error("final result would overwrite a pending word");

endmodule

@@ rtl/rc5_block_decrypt_top.sv @@
// RC5-32 block decrypter top level: config register, sequencer, key table, datapath.
//
// Input channel (in_valid/in_stall/in_word): a word either writes one entry of
// the expanded key table (operation = key write) or carries a ciphertext block
// (operation = decrypt). Key writes give no result; an index beyond the table
// is dropped. Every entry a decrypt reads must be written first.
// Output channel (out_valid/out_stall/out_word): one plaintext word per block.
// cfg_wr_en/cfg_wr_data load round_count; write it only while the block is idle.
// Counts above MAX_ROUNDS saturate; zero runs only the final subtractions.
// A block occupies the shared round unit through its rounds and its final-subtract
// step; the next block is taken no earlier than that final step.
// The key table's registered read ports are fetched one round ahead.
// The result sits in an output register, so input is taken while it waits;
// a stalled receiver only holds the block at its final step until the
// register frees. Reset clears control state and sets round_count to 12;
// the key table is not cleared.
module rc5_block_decrypt_top #(
	parameter int unsigned MAX_ROUNDS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [rc5_pkg::ROUND_CNT_W-1:0] cfg_wr_data,
	input  logic in_valid,
	output logic in_stall,
	input  rc5_pkg::in_word_t in_word,
	output logic out_valid,
	input  logic out_stall,
	output rc5_pkg::out_word_t out_word
);

	localparam int unsigned CntW = $clog2(MAX_ROUNDS + 1);

	logic [rc5_pkg::ROUND_CNT_W-1:0] round_count_q;
	logic key_wr;
	logic [CntW-1:0] rd_round;
	logic [rc5_pkg::WORD_W-1:0] key_hi;
	logic [rc5_pkg::WORD_W-1:0] key_lo;
	logic out_free;
	rc5_pkg::dp_ctl_t ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_count_q <= rc5_pkg::ROUND_RESET;
		end else if (cfg_wr_en) begin
			round_count_q <= cfg_wr_data;
		end
	end

	rc5_seq #(.MAX_ROUNDS(MAX_ROUNDS)) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.operation  (in_word.operation),
		.round_count(round_count_q),
		.out_free   (out_free),
		.in_stall   (in_stall),
		.key_wr     (key_wr),
		.rd_round   (rd_round),
		.ctl        (ctl)
	);

	rc5_key_mem #(.MAX_ROUNDS(MAX_ROUNDS)) u_key_mem (
		.clk     (clk),
		.wr_en   (key_wr),
		.wr_index(in_word.key_index),
		.wr_data (in_word.key_word),
		.rd_round(rd_round),
		.rd_hi   (key_hi),
		.rd_lo   (key_lo)
	);

	rc5_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.cipher_a (in_word.cipher_a),
		.cipher_b (in_word.cipher_b),
		.key_hi   (key_hi),
		.key_lo   (key_lo),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_word (out_word),
		.out_free (out_free)
	);

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the RC5-32 block decrypter: key loads, block decrypts, round settings.
module tb;

	localparam int unsigned ROUND_LIMIT = 16;
	localparam int unsigned KEY_DEPTH = 2 * ROUND_LIMIT + 2;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [rc5_pkg::ROUND_CNT_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	rc5_pkg::in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rc5_pkg::out_word_t out_word;

	// bench copy of the key table and round register
	logic [rc5_pkg::WORD_W-1:0] key_shadow [KEY_DEPTH];
	logic [rc5_pkg::ROUND_CNT_W-1:0] round_setting = rc5_pkg::ROUND_RESET;
	rc5_pkg::out_word_t plain_expect [$];

	int error_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;

	rc5_block_decrypt_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: long hold-off first, otherwise random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin : check_plain
		rc5_pkg::out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (plain_expect.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual a=%h b=%h",
					$time, out_word.plain_a, out_word.plain_b);
				error_count++;
			end else begin
				want = plain_expect.pop_front();
				if (out_word.plain_a !== want.plain_a) begin
					$display("%0t: plain_a mismatch: expected %h, actual %h",
						$time, want.plain_a, out_word.plain_a);
					error_count++;
				end
				if (out_word.plain_b !== want.plain_b) begin
					$display("%0t: plain_b mismatch: expected %h, actual %h",
						$time, want.plain_b, out_word.plain_b);
					error_count++;
				end
			end
		end
	end

	function automatic logic [rc5_pkg::WORD_W-1:0] rotr32(
		input logic [rc5_pkg::WORD_W-1:0] x,
		input logic [4:0] n);
		logic [2*rc5_pkg::WORD_W-1:0] both;
		both = {x, x} >> n;
		return both[rc5_pkg::WORD_W-1:0];
	endfunction

	function automatic rc5_pkg::out_word_t decrypt_predict(
		input logic [rc5_pkg::WORD_W-1:0] ca,
		input logic [rc5_pkg::WORD_W-1:0] cb);
		logic [rc5_pkg::WORD_W-1:0] a;
		logic [rc5_pkg::WORD_W-1:0] b;
		int rounds;
		int i;
		rc5_pkg::out_word_t res;
		a = ca;
		b = cb;
		rounds = (round_setting > ROUND_LIMIT) ? ROUND_LIMIT : round_setting;
		for (i = rounds; i >= 1; i--) begin
			b = rotr32(b - key_shadow[2*i+1], a[4:0]) ^ a;
			a = rotr32(a - key_shadow[2*i], b[4:0]) ^ b;
		end
		res.plain_a = a - key_shadow[0];
		res.plain_b = b - key_shadow[1];
		return res;
	endfunction

	function automatic rc5_pkg::in_word_t key_item(
		input logic [rc5_pkg::KEY_IDX_W-1:0] idx,
		input logic [rc5_pkg::WORD_W-1:0] value);
		rc5_pkg::in_word_t it;
		it.operation = rc5_pkg::OP_KEY_WRITE;
		it.key_index = idx;
		it.key_word = value;
		it.cipher_a = $urandom;
		it.cipher_b = $urandom;
		return it;
	endfunction

	function automatic rc5_pkg::in_word_t block_item(
		input logic [rc5_pkg::WORD_W-1:0] ca,
		input logic [rc5_pkg::WORD_W-1:0] cb);
		rc5_pkg::in_word_t it;
		it.operation = rc5_pkg::OP_DECRYPT;
		it.key_index = rc5_pkg::KEY_IDX_W'($urandom);
		it.key_word = $urandom;
		it.cipher_a = ca;
		it.cipher_b = cb;
		return it;
	endfunction

	// called on a falling edge; returns on a falling edge with valid still high
	// unless an idle gap was taken
	task automatic send_word(input rc5_pkg::in_word_t it);
		in_valid <= 1'b1;
		in_word <= it;
		do @(posedge clk); while (in_stall);
		if (it.operation == rc5_pkg::OP_DECRYPT)
			plain_expect.push_back(decrypt_predict(it.cipher_a, it.cipher_b));
		else if (it.key_index < KEY_DEPTH)
			key_shadow[it.key_index] = it.key_word;
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain_results();
		end_burst();
		while (plain_expect.size() != 0)
			@(negedge clk);
		// a trailing key write gives no word, so let the block settle
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_rounds(input logic [rc5_pkg::ROUND_CNT_W-1:0] value);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		round_setting = value;
	endtask

	task automatic test_key_load();
		int idx;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (idx = 0; idx < KEY_DEPTH; idx++) begin
			if (idx == 0)
				send_word(key_item(rc5_pkg::KEY_IDX_W'(idx), 32'h0000_0000));
			else if (idx == 1)
				send_word(key_item(rc5_pkg::KEY_IDX_W'(idx), 32'hffff_ffff));
			else
				send_word(key_item(rc5_pkg::KEY_IDX_W'(idx), $urandom));
		end
	endtask

	task automatic test_directed_blocks();
		send_word(block_item(32'h0000_0000, 32'h0000_0000));
		send_word(block_item(32'hffff_ffff, 32'hffff_ffff));
		send_word(block_item(32'h0000_0000, 32'hffff_ffff));
		send_word(block_item(32'hffff_ffff, 32'h0000_0000));
		// rotate amount from A is 32, wraps to zero
		send_word(block_item(32'h0000_0020, $urandom));
		// writes past the table end are dropped
		send_word(key_item(rc5_pkg::KEY_IDX_W'(KEY_DEPTH), $urandom));
		send_word(key_item(6'h3f, $urandom));
		send_word(block_item($urandom, $urandom));
		drain_results();
	endtask

	task automatic test_round_extremes();
		logic [rc5_pkg::ROUND_CNT_W-1:0] picks [5];
		int n;
		picks = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31};
		for (n = 0; n < 5; n++) begin
			set_rounds(picks[n]);
			send_word(block_item($urandom, $urandom));
			send_word(block_item($urandom, $urandom));
		end
		drain_results();
	endtask

	task automatic test_random_traffic();
		int send_pcts [4];
		int recv_pcts [4];
		int phase;
		int setting;
		int counted;
		int unsigned pick;
		logic [rc5_pkg::ROUND_CNT_W-1:0] rounds;
		send_pcts = '{0, 67, 0, 33};
		recv_pcts = '{0, 0, 67, 33};
		for (phase = 0; phase < 4; phase++) begin
			for (setting = 0; setting < 4; setting++) begin
				if ($urandom_range(99) < 80)
					rounds = rc5_pkg::ROUND_CNT_W'($urandom_range(16, 1));
				else
					rounds = rc5_pkg::ROUND_CNT_W'($urandom_range(31, 0));
				set_rounds(rounds);
				send_idle_pct = send_pcts[phase];
				recv_stall_pct = recv_pcts[phase];
				counted = 0;
				while (counted < 28) begin
					pick = $urandom_range(99);
					if (pick < 84) begin
						send_word(block_item($urandom, $urandom));
						counted++;
					end else if (pick < 97) begin
						send_word(key_item(
							rc5_pkg::KEY_IDX_W'($urandom_range(KEY_DEPTH - 1, 0)),
							$urandom));
						counted++;
					end else begin
						send_word(key_item(
							rc5_pkg::KEY_IDX_W'($urandom_range(63, KEY_DEPTH)),
							$urandom));
					end
				end
			end
		end
		drain_results();
	endtask

	task automatic test_backpressure();
		int n;
		set_rounds(5'd4);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// receiver holds off while the sender keeps offering, filling the block
		hold_left = 300;
		for (n = 0; n < 24; n++)
			send_word(block_item($urandom, $urandom));
		drain_results();
		for (n = 0; n < 4; n++)
			send_word(block_item($urandom, $urandom));
		drain_results();
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_key_load();
		test_directed_blocks();
		test_round_extremes();
		test_random_traffic();
		test_backpressure();
		drain_results();
		if (error_count == 0 && plain_expect.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
